// ===== design/tlvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types and constants for the TLV message deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 31;
  localparam int CNT_W   = 16;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HDR_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STR_LEN   = 2'd2;

  localparam logic [LEN_W-1:0] RST_MAX_HDR_LEN   = 31'd4096;
  localparam logic [CNT_W-1:0] RST_MAX_CHUNK_CNT = 16'd256;
  localparam logic [LEN_W-1:0] RST_MAX_STR_LEN   = 31'd4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR_BYTE  = 3'd0,
    KIND_INT       = 3'd1,
    KIND_STR_BYTE  = 3'd2,
    KIND_STR_EMPTY = 3'd3,
    KIND_END       = 3'd4,
    KIND_ERR       = 3'd5
  } tok_kind_t;

  typedef enum logic [6:0] {
    PH_HLEN   = 7'b0000001,
    PH_HDR    = 7'b0000010,
    PH_CCNT   = 7'b0000100,
    PH_CTYPE  = 7'b0001000,
    PH_CINT   = 7'b0010000,
    PH_SLEN   = 7'b0100000,
    PH_SBYTES = 7'b1000000
  } phase_t;

  localparam logic [BYTE_W-1:0] TYPE_INT = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_STR = 8'd1;

  typedef struct packed {
    tok_kind_t          kind;
    logic [WORD_W-1:0]  data;
    logic [CNT_W-1:0]   chunk_number;
    logic               element_last;
    logic               message_last;
  } tok_t;

endpackage

// ===== design/tlvd_intf.sv =====
// ----------------------------------------------------------------------------
// tlvd interfaces
// Valid/ready channels for the byte input, the token output and config writes.
// ----------------------------------------------------------------------------
interface tlvd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlvd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tlvd_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlvd_pkg::KIND_W-1:0] token_kind;
  logic [tlvd_pkg::WORD_W-1:0] token_data;
  logic [tlvd_pkg::CNT_W-1:0]  chunk_number;
  logic                        element_last;
  logic                        message_last;

  modport source (output valid, output token_kind, output token_data,
                  output chunk_number, output element_last, output message_last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_data,
                  input chunk_number, input element_last, input message_last,
                  output ready);
endinterface

interface tlvd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlvd_pkg::CFG_IDX_W-1:0] index;
  logic [tlvd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/tlv_message_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tlv_message_deframer_core
// A token is registered in the output register, or in the skid during a stall.
// One byte per cycle while the skid is empty; phase/counter update is one pass.
// A two-deep output (register plus skid) keeps input flowing during one stall.
// Reset (rst_n, sync): start of message, counters cleared, error clear,
// limits back to 4096 / 256 / 4096.
// ----------------------------------------------------------------------------
module tlv_message_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  tlvd_in_if.sink     in_ch,
  tlvd_out_if.source  out_ch,
  tlvd_cfg_if.sink    cfg_ch
);
  import tlvd_pkg::*;

  // limits
  logic [LEN_W-1:0] max_hdr_len_r;
  logic [CNT_W-1:0] max_chunk_cnt_r;
  logic [LEN_W-1:0] max_str_len_r;

  // deframer state
  phase_t           phase_r, phase_nxt;
  logic [1:0]       wpos_r, wpos_nxt;
  logic [23:0]      pw_r, pw_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [CNT_W-1:0] chunks_left_r, chunks_left_nxt;
  logic [CNT_W-1:0] chunk_pos_r, chunk_pos_nxt;
  logic             sticky_r, sticky_nxt;

  // output register and skid
  tok_t out_r, skid_r;
  logic out_v_r, skid_v_r;

  tok_t              res;
  logic              res_v;
  logic              in_fire;
  logic [BYTE_W-1:0] b;
  logic [WORD_W-1:0] word;
  logic [LEN_W-1:0]  bl_dec;
  logic              bl_last;
  logic              cl_last;
  logic              word_neg;
  logic              hlen_big, ccnt_big, slen_big;

  assign in_ch.ready  = !skid_v_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign b        = in_ch.in_byte;
  assign word     = {b, pw_r};
  assign word_neg = b[7];
  assign bl_dec   = bytes_left_r - 1'b1;
  assign bl_last  = (bytes_left_r == {{(LEN_W-1){1'b0}}, 1'b1});
  assign cl_last  = (chunks_left_r == {{(CNT_W-1){1'b0}}, 1'b1});
  assign hlen_big = word[LEN_W-1:0] > max_hdr_len_r;
  assign ccnt_big = (word[LEN_W-1:CNT_W] != '0) || (word[CNT_W-1:0] > max_chunk_cnt_r);
  assign slen_big = word[LEN_W-1:0] > max_str_len_r;

  always_comb begin
    phase_nxt       = phase_r;
    wpos_nxt        = wpos_r;
    pw_nxt          = pw_r;
    bytes_left_nxt  = bytes_left_r;
    chunks_left_nxt = chunks_left_r;
    chunk_pos_nxt   = chunk_pos_r;
    sticky_nxt      = sticky_r;
    res_v           = 1'b0;
    res             = '0;
    res.kind        = KIND_ERR;

    if (sticky_r) begin
      res_v = 1'b1;
    end else begin
      case (phase_r)
        PH_HDR: begin
          bytes_left_nxt   = bl_dec;
          res_v            = 1'b1;
          res.kind         = KIND_HDR_BYTE;
          res.data         = {{(WORD_W-BYTE_W){1'b0}}, b};
          res.element_last = bl_last;
          if (bl_last) begin
            phase_nxt = PH_CCNT;
          end
        end
        PH_SBYTES: begin
          bytes_left_nxt   = bl_dec;
          res_v            = 1'b1;
          res.kind         = KIND_STR_BYTE;
          res.data         = {{(WORD_W-BYTE_W){1'b0}}, b};
          res.chunk_number = chunk_pos_r;
          res.element_last = bl_last;
          res.message_last = bl_last && cl_last;
          if (bl_last) begin
            chunks_left_nxt = chunks_left_r - 1'b1;
            chunk_pos_nxt   = cl_last ? '0 : chunk_pos_r + 1'b1;
            phase_nxt       = cl_last ? PH_HLEN : PH_CTYPE;
          end
        end
        PH_CTYPE: begin
          if (b == TYPE_INT) begin
            phase_nxt = PH_CINT;
          end else if (b == TYPE_STR) begin
            phase_nxt = PH_SLEN;
          end else begin
            sticky_nxt = 1'b1;
            res_v      = 1'b1;
          end
        end
        PH_HLEN, PH_CCNT, PH_CINT, PH_SLEN: begin
          if (wpos_r != 2'd3) begin
            // little-endian assembly of the low three bytes
            case (wpos_r)
              2'd0:    pw_nxt = {16'd0, b};
              2'd1:    pw_nxt = {8'd0, b, pw_r[7:0]};
              default: pw_nxt = {b, pw_r[15:0]};
            endcase
            wpos_nxt = wpos_r + 1'b1;
          end else begin
            pw_nxt   = '0;
            wpos_nxt = '0;
            case (phase_r)
              PH_HLEN: begin
                if (word_neg || hlen_big) begin
                  sticky_nxt = 1'b1;
                  res_v      = 1'b1;
                end else if (word == '0) begin
                  phase_nxt = PH_CCNT;
                end else begin
                  bytes_left_nxt = word[LEN_W-1:0];
                  phase_nxt      = PH_HDR;
                end
              end
              PH_CCNT: begin
                if (word_neg || ccnt_big) begin
                  sticky_nxt = 1'b1;
                  res_v      = 1'b1;
                end else if (word == '0) begin
                  res_v            = 1'b1;
                  res.kind         = KIND_END;
                  res.message_last = 1'b1;
                  phase_nxt        = PH_HLEN;
                  chunk_pos_nxt    = '0;
                end else begin
                  chunks_left_nxt = word[CNT_W-1:0];
                  chunk_pos_nxt   = '0;
                  phase_nxt       = PH_CTYPE;
                end
              end
              PH_CINT: begin
                res_v            = 1'b1;
                res.kind         = KIND_INT;
                res.data         = word;
                res.chunk_number = chunk_pos_r;
                res.message_last = cl_last;
                chunks_left_nxt  = chunks_left_r - 1'b1;
                chunk_pos_nxt    = cl_last ? '0 : chunk_pos_r + 1'b1;
                phase_nxt        = cl_last ? PH_HLEN : PH_CTYPE;
              end
              default: begin // string length
                if (word_neg || slen_big) begin
                  sticky_nxt = 1'b1;
                  res_v      = 1'b1;
                end else if (word == '0) begin
                  res_v            = 1'b1;
                  res.kind         = KIND_STR_EMPTY;
                  res.chunk_number = chunk_pos_r;
                  res.element_last = 1'b1;
                  res.message_last = cl_last;
                  chunks_left_nxt  = chunks_left_r - 1'b1;
                  chunk_pos_nxt    = cl_last ? '0 : chunk_pos_r + 1'b1;
                  phase_nxt        = cl_last ? PH_HLEN : PH_CTYPE;
                end else begin
                  bytes_left_nxt = word[LEN_W-1:0];
                  phase_nxt      = PH_SBYTES;
                end
              end
            endcase
          end
        end
        default: begin
          phase_nxt = PH_HLEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HLEN;
      wpos_r        <= '0;
      pw_r          <= '0;
      bytes_left_r  <= '0;
      chunks_left_r <= '0;
      chunk_pos_r   <= '0;
      sticky_r      <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      wpos_r        <= wpos_nxt;
      pw_r          <= pw_nxt;
      bytes_left_r  <= bytes_left_nxt;
      chunks_left_r <= chunks_left_nxt;
      chunk_pos_r   <= chunk_pos_nxt;
      sticky_r      <= sticky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_hdr_len_r   <= RST_MAX_HDR_LEN;
      max_chunk_cnt_r <= RST_MAX_CHUNK_CNT;
      max_str_len_r   <= RST_MAX_STR_LEN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAX_HDR_LEN:   max_hdr_len_r   <= cfg_ch.data[LEN_W-1:0];
        CFG_MAX_CHUNK_CNT: max_chunk_cnt_r <= cfg_ch.data[CNT_W-1:0];
        CFG_MAX_STR_LEN:   max_str_len_r   <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // output stage: token moves out, skid catches a token during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r  <= skid_v_r || (in_fire && res_v);
      skid_v_r <= 1'b0;
    end else if (in_fire && res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (in_fire && res_v) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.token_kind   = out_r.kind;
  assign out_ch.token_data   = out_r.data;
  assign out_ch.chunk_number = out_r.chunk_number;
  assign out_ch.element_last = out_r.element_last;
  assign out_ch.message_last = out_r.message_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a token while output register is empty");

  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |=> sticky_r)
    else $error("sticky error cleared without reset");

  a_err_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sticky_r) |=> out_v_r)
    else $error("byte taken in error state produced no token");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == KIND_END) |-> out_r.message_last)
    else $error("end token without message_last");

endmodule
